// ===== design/isfp_pkg.sv =====
`default_nettype none

package isfp_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int MAX_FRAME_BYTES  = 64;
  localparam int POS_W            = 7;
  localparam int SLOT_W           = 4;
  localparam int CFG_IDX_W        = 8;

  localparam int IMU_MIN_BYTES  = 60;
  localparam int AHRS_MIN_BYTES = 52;

  localparam int FIRST_WORD_OFFSET = 7;
  localparam int IMU_WORDS         = 9;
  localparam int AHRS_WORDS        = 10;
  localparam int IMU_STAMP_OFFSET  = 55;
  localparam int AHRS_STAMP_OFFSET = 47;

  // every word offset is 3 mod 4: first byte sits in bank 3 of row r,
  // the other three in banks 0..2 of row r + 1
  localparam int FIRST_WORD_ROW = (FIRST_WORD_OFFSET - 3) / 4;
  localparam int IMU_STAMP_ROW  = (IMU_STAMP_OFFSET - 3) / 4;
  localparam int AHRS_STAMP_ROW = (AHRS_STAMP_OFFSET - 3) / 4;

  localparam logic KIND_IMU  = 1'b0;
  localparam logic KIND_AHRS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMU_TYPE_CODE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMU_LENGTH_CODE  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AHRS_TYPE_CODE   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AHRS_LENGTH_CODE = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMU_FRAME_BYTES  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AHRS_FRAME_BYTES = 8'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic              take_byte;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic last_out;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/isfp_ctrl.sv =====
`default_nettype none

module isfp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire isfp_pkg::dp_status_t st,
  output isfp_pkg::ctrl_cmd_t      cmd
);
  import isfp_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_slot   = slot_r;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && st.frame_good) begin
          state_nxt = ST_LOAD;
          slot_nxt  = '0;
        end
      end
      ST_LOAD: begin
        cmd.rd_en = 1'b1;
        slot_nxt  = slot_r + 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.last_out) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            slot_nxt  = slot_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/isfp_datapath.sv =====
`default_nettype none

module isfp_datapath #(
  parameter int BUFFER_BYTES = isfp_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic                           cfg_we,
  input  wire logic [isfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire isfp_pkg::ctrl_cmd_t            cmd,
  output isfp_pkg::dp_status_t                st,
  output logic                                frame_kind,
  output logic [isfp_pkg::SLOT_W-1:0]         word_slot,
  output logic [31:0]                         word_bits,
  output logic                                last_word
);
  import isfp_pkg::*;

  localparam int STORE_BYTES = (BUFFER_BYTES < MAX_FRAME_BYTES) ? BUFFER_BYTES
                                                                : MAX_FRAME_BYTES;
  localparam int AW   = $clog2(STORE_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = 2 ** RW;

  logic [7:0]       head_r, tail_r, imu_type_r, imu_len_code_r, ahrs_type_r, ahrs_len_code_r;
  logic [POS_W-1:0] imu_bytes_r, ahrs_bytes_r;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]       prev_r;
  logic [7:0]       byte1_r, byte1_nxt;
  logic             kind_r, kind_nxt;
  logic [POS_W-1:0] imu_len, ahrs_len, frame_len;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic [RW-1:0]    rd_row;
  logic             rd_last;
  logic [7:0]       rd_byte_r [4];
  logic [SLOT_W-1:0] slot_out_r;
  logic             last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r          <= 8'd252;
      tail_r          <= 8'd253;
      imu_type_r      <= 8'd64;
      imu_len_code_r  <= 8'd56;
      ahrs_type_r     <= 8'd65;
      ahrs_len_code_r <= 8'd48;
      imu_bytes_r     <= POS_W'(64);
      ahrs_bytes_r    <= POS_W'(56);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD_BYTE:        head_r          <= cfg_data;
        REG_TAIL_BYTE:        tail_r          <= cfg_data;
        REG_IMU_TYPE_CODE:    imu_type_r      <= cfg_data;
        REG_IMU_LENGTH_CODE:  imu_len_code_r  <= cfg_data;
        REG_AHRS_TYPE_CODE:   ahrs_type_r     <= cfg_data;
        REG_AHRS_LENGTH_CODE: ahrs_len_code_r <= cfg_data;
        REG_IMU_FRAME_BYTES:  imu_bytes_r     <= cfg_data[POS_W-1:0];
        REG_AHRS_FRAME_BYTES: ahrs_bytes_r    <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign imu_len  = (imu_bytes_r < POS_W'(IMU_MIN_BYTES))  ? POS_W'(IMU_MIN_BYTES)  :
                    (imu_bytes_r > POS_W'(STORE_BYTES))    ? POS_W'(STORE_BYTES)    :
                    imu_bytes_r;
  assign ahrs_len = (ahrs_bytes_r < POS_W'(AHRS_MIN_BYTES)) ? POS_W'(AHRS_MIN_BYTES) :
                    (ahrs_bytes_r > POS_W'(STORE_BYTES))    ? POS_W'(STORE_BYTES)    :
                    ahrs_bytes_r;
  assign frame_len = (kind_r == KIND_AHRS) ? ahrs_len : imu_len;
  assign pos_inc   = pos_r + 1'b1;
  assign wr_addr   = pos_r[AW-1:0];

  always_comb begin
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    byte1_nxt     = byte1_r;
    wr_en         = 1'b0;
    st.frame_good = 1'b0;
    if (cmd.take_byte) begin
      if (pos_r == '0) begin
        if (prev_r == tail_r && rx_byte == head_r) begin
          wr_en   = 1'b1;
          pos_nxt = POS_W'(1);
        end
      end else begin
        wr_en   = pos_r < POS_W'(STORE_BYTES);
        pos_nxt = pos_inc;
        if (pos_r == POS_W'(1)) begin
          byte1_nxt = rx_byte;
        end
        if (pos_inc == POS_W'(3)) begin
          if (byte1_r == imu_type_r && rx_byte == imu_len_code_r) begin
            kind_nxt = KIND_IMU;
          end else if (byte1_r == ahrs_type_r && rx_byte == ahrs_len_code_r) begin
            kind_nxt = KIND_AHRS;
          end else begin
            pos_nxt = '0;
          end
        end else if (pos_inc >= frame_len) begin
          pos_nxt       = '0;
          st.frame_good = (rx_byte == tail_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
      kind_r <= KIND_IMU;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      if (cmd.take_byte) begin
        prev_r <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte1_r <= byte1_nxt;
  end

  // word read: timestamp row on the last slot, otherwise consecutive rows
  always_comb begin
    rd_last = (cmd.rd_slot == ((kind_r == KIND_AHRS) ? SLOT_W'(AHRS_WORDS)
                                                      : SLOT_W'(IMU_WORDS)));
    if (rd_last) begin
      rd_row = (kind_r == KIND_AHRS) ? RW'(AHRS_STAMP_ROW) : RW'(IMU_STAMP_ROW);
    end else begin
      rd_row = RW'(FIRST_WORD_ROW) + RW'(cmd.rd_slot);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [RW-1:0] row;

    assign row = (k == 3) ? rd_row : rd_row + 1'b1;

    always_ff @(posedge clk) begin
      if (wr_en && wr_addr[1:0] == 2'(k)) begin
        mem[wr_addr[AW-1:2]] <= rx_byte;
      end
      if (cmd.rd_en) begin
        rd_byte_r[k] <= mem[row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      slot_out_r <= cmd.rd_slot;
      last_out_r <= rd_last;
    end
  end

  assign st.last_out = last_out_r;
  assign frame_kind  = kind_r;
  assign word_slot   = slot_out_r;
  assign last_word   = last_out_r;
  assign word_bits   = {rd_byte_r[2], rd_byte_r[1], rd_byte_r[0], rd_byte_r[3]};

endmodule

`default_nettype wire

// ===== design/imu_serial_frame_parser.sv =====
// channel  | handshake            | payload
// in       | in_valid / in_ready  | in_rx_byte
// out      | out_valid / out_ready| out_frame_kind, out_word_slot, out_word_bits, out_last_word
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte a cycle while scanning and buffering a frame.
// A good tail starts a run: the four byte banks are read first, then one word a cycle while
// out_ready is high (10 IMU or 11 AHRS words); no byte is taken until the last word leaves.
// out_ready low holds the current word. cfg_ready is always high.
// Reset is synchronous: registers to defaults, out of frame; no clearing pass.
`default_nettype none

module imu_serial_frame_parser #(
  parameter int BUFFER_BYTES = isfp_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_frame_kind,
  output logic [isfp_pkg::SLOT_W-1:0]         out_word_slot,
  output logic [31:0]                         out_word_bits,
  output logic                                out_last_word,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [isfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import isfp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  isfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  isfp_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (in_rx_byte),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .frame_kind (out_frame_kind),
    .word_slot  (out_word_slot),
    .word_bits  (out_word_bits),
    .last_word  (out_last_word)
  );

`ifndef SYNTHESIS
  a_no_take_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("byte taken during word run");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |->
      ((out_frame_kind == KIND_IMU && out_word_slot == SLOT_W'(IMU_WORDS)) ||
       (out_frame_kind == KIND_AHRS && out_word_slot == SLOT_W'(AHRS_WORDS))))
    else $error("timestamp beat on wrong slot");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (!out_valid && in_ready))
    else $error("run did not end after last beat");

  a_slot_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_slot == $past(out_word_slot) + 1'b1))
    else $error("slot did not advance");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import isfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF       = 150;

  typedef enum {SEEN_NONE, SEEN_IMU, SEEN_AHRS} seen_t;
  typedef enum {FLAW_NONE, FLAW_TAIL, FLAW_CODES, FLAW_SHORT} frame_flaw_t;

  typedef struct {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       bits;
    logic              last;
  } word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_frame_kind;
  logic [SLOT_W-1:0]    out_word_slot;
  logic [31:0]          out_word_bits;
  logic                 out_last_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  // decoder shadow state
  logic [7:0] reg_val [0:7];
  logic [7:0] fstore  [0:BUFFER_BYTES_DEF-1];
  int         fpos;
  logic [7:0] last_rx;
  seen_t      seen;

  word_t words_due [$];

  bit stall_on;
  int hold_cycles;
  int bytes_sent;
  int words_queued;
  int words_checked;
  int frames_good;
  int frames_dropped;
  int cfg_writes;
  int err_count;

  imu_serial_frame_parser DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_kind (out_frame_kind),
    .out_word_slot  (out_word_slot),
    .out_word_bits  (out_word_bits),
    .out_last_word  (out_last_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int frame_bytes(input logic ahrs);
    int n;
    int lo;
    n  = ahrs ? reg_val[REG_AHRS_FRAME_BYTES] : reg_val[REG_IMU_FRAME_BYTES];
    lo = ahrs ? AHRS_MIN_BYTES : IMU_MIN_BYTES;
    if (n < lo) n = lo;
    if (n > MAX_FRAME_BYTES) n = MAX_FRAME_BYTES;
    if (n > BUFFER_BYTES_DEF) n = BUFFER_BYTES_DEF;
    return n;
  endfunction

  function automatic logic [31:0] word_at(input int off);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++)
      if (off + k < BUFFER_BYTES_DEF) w[8*k +: 8] = fstore[off + k];
    return w;
  endfunction

  task automatic queue_word(input logic ahrs, input int slot, input logic [31:0] bits,
                            input logic last);
    word_t w;
    w.kind = ahrs ? KIND_AHRS : KIND_IMU;
    w.slot = slot;
    w.bits = bits;
    w.last = last;
    words_due.push_back(w);
    words_queued++;
  endtask

  task automatic parse_byte(input logic [7:0] rx);
    logic [7:0] prev;
    logic       ahrs;
    int         count;
    prev    = last_rx;
    last_rx = rx;
    if (fpos == 0) begin
      if (prev == reg_val[REG_TAIL_BYTE] && rx == reg_val[REG_HEAD_BYTE]) begin
        fstore[0] = rx;
        fpos = 1;
        seen = SEEN_NONE;
      end
    end else begin
      if (fpos < BUFFER_BYTES_DEF) fstore[fpos] = rx;
      fpos++;
      if (fpos == 3) begin
        if (fstore[1] == reg_val[REG_IMU_TYPE_CODE] &&
            fstore[2] == reg_val[REG_IMU_LENGTH_CODE]) begin
          seen = SEEN_IMU;
        end else if (fstore[1] == reg_val[REG_AHRS_TYPE_CODE] &&
                     fstore[2] == reg_val[REG_AHRS_LENGTH_CODE]) begin
          seen = SEEN_AHRS;
        end else begin
          fpos = 0;
          seen = SEEN_NONE;
          frames_dropped++;
        end
      end else if (seen != SEEN_NONE) begin
        ahrs = (seen == SEEN_AHRS);
        if (fpos >= frame_bytes(ahrs)) begin
          fpos = 0;
          seen = SEEN_NONE;
          if (rx == reg_val[REG_TAIL_BYTE]) begin
            count = ahrs ? AHRS_WORDS : IMU_WORDS;
            for (int i = 0; i < count; i++)
              queue_word(ahrs, i, word_at(FIRST_WORD_OFFSET + 4 * i), 1'b0);
            queue_word(ahrs, count,
                       word_at(ahrs ? AHRS_STAMP_OFFSET : IMU_STAMP_OFFSET), 1'b1);
            frames_good++;
          end else begin
            frames_dropped++;
          end
        end
      end else if (fpos >= BUFFER_BYTES_DEF) begin
        fpos = 0;
        seen = SEEN_NONE;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = stall_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_AHRS_FRAME_BYTES)
      reg_val[idx] = (idx >= REG_IMU_FRAME_BYTES) ? (val & 8'h7F) : val;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // input at rest, all words out, then a wait for a frame still being loaded
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic open_frame(input logic [7:0] t, input logic [7:0] l, input int stop,
                            input bit inject);
    send_byte(reg_val[REG_TAIL_BYTE]);
    send_byte(reg_val[REG_HEAD_BYTE]);
    send_byte(t);
    send_byte(l);
    for (int p = 3; p < stop; p++) begin
      if (inject && p == 10) send_byte(reg_val[REG_TAIL_BYTE]);
      else if (inject && p == 11) send_byte(reg_val[REG_HEAD_BYTE]);
      else if (inject && p == 12) send_byte(8'h00);
      else if (inject && p == 13) send_byte(8'hFF);
      else send_byte($urandom);
    end
  endtask

  task automatic send_frame(input logic ahrs, input frame_flaw_t flaw, input bit inject);
    logic [7:0] t;
    logic [7:0] l;
    logic [7:0] b;
    int         total;
    int         stop;
    total = frame_bytes(ahrs);
    t = ahrs ? reg_val[REG_AHRS_TYPE_CODE] : reg_val[REG_IMU_TYPE_CODE];
    l = ahrs ? reg_val[REG_AHRS_LENGTH_CODE] : reg_val[REG_IMU_LENGTH_CODE];
    if (flaw == FLAW_CODES) begin
      do begin
        t = $urandom;
        l = $urandom;
      end while ((t == reg_val[REG_IMU_TYPE_CODE] && l == reg_val[REG_IMU_LENGTH_CODE]) ||
                 (t == reg_val[REG_AHRS_TYPE_CODE] && l == reg_val[REG_AHRS_LENGTH_CODE]));
    end
    case (flaw)
      FLAW_CODES: stop = 3 + $urandom_range(0, 4);
      FLAW_SHORT: stop = $urandom_range(4, total - 2);
      default:    stop = total - 1;
    endcase
    open_frame(t, l, stop, inject);
    if (flaw == FLAW_NONE) begin
      send_byte(reg_val[REG_TAIL_BYTE]);
    end else if (flaw == FLAW_TAIL) begin
      b = $urandom;
      if (b == reg_val[REG_TAIL_BYTE]) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic test_default_frames();
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_bad_codes();
    send_frame(1'b0, FLAW_CODES, 1'b0);
    // type of one kind with length code of the other
    open_frame(reg_val[REG_IMU_TYPE_CODE], reg_val[REG_AHRS_LENGTH_CODE], 5, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_bad_tail();
    send_frame(1'b0, FLAW_TAIL, 1'b0);
    send_frame(1'b1, FLAW_TAIL, 1'b0);
    send_frame(1'b0, FLAW_NONE, 1'b0);
  endtask

  task automatic test_head_inside_frame();
    send_frame(1'b0, FLAW_NONE, 1'b1);
    send_frame(1'b1, FLAW_NONE, 1'b1);
  endtask

  task automatic test_ignored_index();
    settle();
    write_reg(8'd8, $urandom);
    write_reg(8'd255, $urandom);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_shared_codes();
    settle();
    write_reg(REG_AHRS_TYPE_CODE, reg_val[REG_IMU_TYPE_CODE]);
    write_reg(REG_AHRS_LENGTH_CODE, reg_val[REG_IMU_LENGTH_CODE]);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    settle();
    write_reg(REG_AHRS_TYPE_CODE, 8'd65);
    write_reg(REG_AHRS_LENGTH_CODE, 8'd48);
  endtask

  task automatic test_length_saturation();
    settle();
    write_reg(REG_IMU_FRAME_BYTES, 8'h80);
    write_reg(REG_AHRS_FRAME_BYTES, 8'hFF);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
    settle();
    write_reg(REG_IMU_FRAME_BYTES, 8'h7F);
    write_reg(REG_AHRS_FRAME_BYTES, 8'h00);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_extreme_bytes();
    settle();
    write_reg(REG_HEAD_BYTE, 8'h00);
    write_reg(REG_TAIL_BYTE, 8'hFF);
    write_reg(REG_IMU_TYPE_CODE, 8'h00);
    write_reg(REG_IMU_LENGTH_CODE, 8'hFF);
    write_reg(REG_AHRS_TYPE_CODE, 8'hFF);
    write_reg(REG_AHRS_LENGTH_CODE, 8'h00);
    write_reg(REG_IMU_FRAME_BYTES, IMU_MIN_BYTES);
    write_reg(REG_AHRS_FRAME_BYTES, AHRS_MIN_BYTES);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
    settle();
    write_reg(REG_HEAD_BYTE, 8'hFF);
    write_reg(REG_TAIL_BYTE, 8'h00);
    write_reg(REG_IMU_TYPE_CODE, 8'hFF);
    write_reg(REG_IMU_LENGTH_CODE, 8'hFF);
    write_reg(REG_AHRS_TYPE_CODE, 8'h00);
    write_reg(REG_AHRS_LENGTH_CODE, 8'h00);
    write_reg(REG_IMU_FRAME_BYTES, MAX_FRAME_BYTES);
    write_reg(REG_AHRS_FRAME_BYTES, MAX_FRAME_BYTES);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_length_lowered_mid_frame();
    logic [7:0] b;
    settle();
    write_reg(REG_IMU_FRAME_BYTES, MAX_FRAME_BYTES);
    write_reg(REG_AHRS_FRAME_BYTES, MAX_FRAME_BYTES);
    open_frame(reg_val[REG_IMU_TYPE_CODE], reg_val[REG_IMU_LENGTH_CODE], 62, 1'b0);
    settle();
    write_reg(REG_IMU_FRAME_BYTES, IMU_MIN_BYTES);
    send_byte(reg_val[REG_TAIL_BYTE]);
    open_frame(reg_val[REG_AHRS_TYPE_CODE], reg_val[REG_AHRS_LENGTH_CODE], 58, 1'b0);
    settle();
    write_reg(REG_AHRS_FRAME_BYTES, AHRS_MIN_BYTES);
    b = ~reg_val[REG_TAIL_BYTE];
    send_byte(b);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic test_output_backpressure();
    stall_on    = 1'b1;
    hold_cycles = HOLD_OFF;
    send_frame(1'b1, FLAW_NONE, 1'b0);
    send_frame(1'b0, FLAW_NONE, 1'b0);
    send_frame(1'b1, FLAW_NONE, 1'b0);
  endtask

  task automatic random_config(input int phase);
    logic [7:0] h;
    logic [7:0] tl;
    h  = $urandom;
    tl = $urandom;
    if (tl == h) tl = h ^ 8'h01;
    write_reg(REG_HEAD_BYTE, h);
    write_reg(REG_TAIL_BYTE, tl);
    write_reg(REG_IMU_TYPE_CODE, $urandom);
    write_reg(REG_IMU_LENGTH_CODE, $urandom);
    write_reg(REG_AHRS_TYPE_CODE, $urandom);
    write_reg(REG_AHRS_LENGTH_CODE, $urandom);
    case (phase)
      0: begin
        write_reg(REG_IMU_FRAME_BYTES, IMU_MIN_BYTES);
        write_reg(REG_AHRS_FRAME_BYTES, AHRS_MIN_BYTES);
      end
      1: begin
        write_reg(REG_IMU_FRAME_BYTES, MAX_FRAME_BYTES);
        write_reg(REG_AHRS_FRAME_BYTES, MAX_FRAME_BYTES);
      end
      default: begin
        if ($urandom_range(0, 4) == 0) write_reg(REG_IMU_FRAME_BYTES, $urandom);
        else write_reg(REG_IMU_FRAME_BYTES, $urandom_range(IMU_MIN_BYTES, MAX_FRAME_BYTES));
        if ($urandom_range(0, 4) == 0) write_reg(REG_AHRS_FRAME_BYTES, $urandom);
        else write_reg(REG_AHRS_FRAME_BYTES, $urandom_range(AHRS_MIN_BYTES, MAX_FRAME_BYTES));
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    int noise;
    int w0;
    int s;
    int n;
    int r;
    phase = 0;
    noise = 0;
    start = bytes_sent;
    w0    = words_queued;
    while (bytes_sent - start - noise < 460 || words_queued - w0 < 40) begin
      settle();
      random_config(phase);
      stall_on = (phase % 3 != 2);
      s = bytes_sent;
      while (bytes_sent - s < 120) begin
        r = $urandom_range(0, 9);
        if (r <= 5) begin
          send_frame($urandom_range(0, 1), FLAW_NONE, 1'b0);
        end else if (r == 6) begin
          send_frame($urandom_range(0, 1), FLAW_TAIL, 1'b0);
        end else if (r == 7) begin
          send_frame($urandom_range(0, 1), FLAW_CODES, 1'b0);
        end else if (r == 8) begin
          send_frame($urandom_range(0, 1), FLAW_SHORT, 1'b0);
        end else begin
          n = bytes_sent;
          repeat ($urandom_range(1, 12)) send_byte($urandom);
          noise += bytes_sent - n;
        end
      end
      phase++;
    end
    stall_on = 1'b1;
  endtask

  // result side: random stalls per beat, plus a long hold-off on request
  initial begin : out_side
    int w;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        w = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      w = stall_on ? $urandom_range(0, 4) : 0;
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_words
    word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: slot %0d bits %h", out_word_slot, out_word_bits);
        err_count++;
      end else begin
        e = words_due.pop_front();
        words_checked++;
        if (out_frame_kind !== e.kind) begin
          $error("frame_kind: expected %0d, got %0d", e.kind, out_frame_kind);
          err_count++;
        end
        if (out_word_slot !== e.slot) begin
          $error("word_slot: expected %0d, got %0d", e.slot, out_word_slot);
          err_count++;
        end
        if (out_word_bits !== e.bits) begin
          $error("word_bits: expected %h, got %h", e.bits, out_word_bits);
          err_count++;
        end
        if (out_last_word !== e.last) begin
          $error("last_word: expected %0d, got %0d", e.last, out_last_word);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("imu_serial_frame_parser verification failed");
    $finish;
  end

  initial begin
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = 8'h00;
    rst_n       = 1'b0;
    stall_on    = 1'b1;
    hold_cycles = 0;
    reg_val[REG_HEAD_BYTE]        = 8'd252;
    reg_val[REG_TAIL_BYTE]        = 8'd253;
    reg_val[REG_IMU_TYPE_CODE]    = 8'd64;
    reg_val[REG_IMU_LENGTH_CODE]  = 8'd56;
    reg_val[REG_AHRS_TYPE_CODE]   = 8'd65;
    reg_val[REG_AHRS_LENGTH_CODE] = 8'd48;
    reg_val[REG_IMU_FRAME_BYTES]  = 8'd64;
    reg_val[REG_AHRS_FRAME_BYTES] = 8'd56;
    fpos    = 0;
    last_rx = 8'h00;
    seen    = SEEN_NONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frames();
    test_bad_codes();
    test_bad_tail();
    test_head_inside_frame();
    test_ignored_index();
    test_shared_codes();
    test_length_saturation();
    test_extreme_bytes();
    test_length_lowered_mid_frame();
    test_output_backpressure();
    test_random_traffic();

    settle();
    $display("run: %0d bytes in, %0d register writes, hold-off of %0d cycles on the output",
             bytes_sent, cfg_writes, HOLD_OFF);
    $display("run: %0d frames decoded, %0d frames dropped, %0d words compared",
             frames_good, frames_dropped, words_checked);
    if (err_count == 0) begin
      $display("imu_serial_frame_parser verification clean");
    end else begin
      $display("imu_serial_frame_parser verification failed");
    end
    $finish;
  end

endmodule
